// File: rtl/button_counter_seven_segment_display_core_defines.svh
// Assertion macros for the press counter display RTL.
`ifndef BUTTON_COUNTER_SEVEN_SEGMENT_DISPLAY_CORE_DEFINES_SVH
`define BUTTON_COUNTER_SEVEN_SEGMENT_DISPLAY_CORE_DEFINES_SVH

// Checks a consequence in the same cycle as its cause.
`define BCSSD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcssd: same-cycle check failed");

// Checks a consequence in the cycle after its cause.
`define BCSSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcssd: next-cycle check failed");

`endif

// File: rtl/bcssd_pkg.sv
// Types, constants and decode functions for the press counter display.
`default_nettype none

package bcssd_pkg;

  localparam int COUNT_W = 10;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 24;

  // Item kind carried in tuser.
  localparam logic FUNC_POLL = 1'b0;
  localparam logic FUNC_SHOW = 1'b1;

  // Digit numbers, thousands first.
  localparam logic [2:0] DIGIT_THOU = 3'd1;
  localparam logic [2:0] DIGIT_HUND = 3'd2;
  localparam logic [2:0] DIGIT_TENS = 3'd3;
  localparam logic [2:0] DIGIT_ONES = 3'd4;

  // Decoder select codes.
  localparam logic [2:0] CODE_DIG1 = 3'd4;
  localparam logic [2:0] CODE_DIG2 = 3'd3;
  localparam logic [2:0] CODE_DIG3 = 3'd1;
  localparam logic [2:0] CODE_DIG4 = 3'd0;
  localparam logic [2:0] CODE_IDLE = 3'd4;
  localparam logic [2:0] CODE_BUTTONS = 3'd7;

  localparam logic [7:0] BUTTONS_IDLE = 8'hFF;
  localparam logic [7:0] SEG_BLANK = 8'hFF;

  localparam logic [COUNT_W:0] COUNT_WRAP_AT = 11'd1024;
  localparam logic [COUNT_W:0] COUNT_DROP = 11'd1023;

  // Leading zero thresholds.
  localparam logic [COUNT_W-1:0] LZ_TENS = 10'd10;
  localparam logic [COUNT_W-1:0] LZ_HUND = 10'd100;
  localparam logic [COUNT_W-1:0] LZ_THOU = 10'd1000;

  typedef logic [3:0][3:0] bcd4_t;

  typedef struct packed {
    logic       func;
    logic [7:0] buttons;
    logic [2:0] digit;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               taken;
  } poll_res_t;

  typedef struct packed {
    logic [7:0]         segments;
    logic [2:0]         digit_code;
    logic [COUNT_W-1:0] count;
    logic               press_taken;
  } out_item_t;

  // Active-low segment pattern of one decimal digit.
  function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h98;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // BCD of the upper five count bits times 32.
  function automatic logic [15:0] hi_bcd(input logic [4:0] h);
    logic [15:0] b;
    case (h)
      5'd0:  b = 16'h0000;  5'd1:  b = 16'h0032;  5'd2:  b = 16'h0064;
      5'd3:  b = 16'h0096;  5'd4:  b = 16'h0128;  5'd5:  b = 16'h0160;
      5'd6:  b = 16'h0192;  5'd7:  b = 16'h0224;  5'd8:  b = 16'h0256;
      5'd9:  b = 16'h0288;  5'd10: b = 16'h0320;  5'd11: b = 16'h0352;
      5'd12: b = 16'h0384;  5'd13: b = 16'h0416;  5'd14: b = 16'h0448;
      5'd15: b = 16'h0480;  5'd16: b = 16'h0512;  5'd17: b = 16'h0544;
      5'd18: b = 16'h0576;  5'd19: b = 16'h0608;  5'd20: b = 16'h0640;
      5'd21: b = 16'h0672;  5'd22: b = 16'h0704;  5'd23: b = 16'h0736;
      5'd24: b = 16'h0768;  5'd25: b = 16'h0800;  5'd26: b = 16'h0832;
      5'd27: b = 16'h0864;  5'd28: b = 16'h0896;  5'd29: b = 16'h0928;
      5'd30: b = 16'h0960;  5'd31: b = 16'h0992;
      default: b = 16'h0000;
    endcase
    return b;
  endfunction

  // Decimal digits of a count: table for the upper bits, then a short BCD add.
  function automatic bcd4_t count_to_bcd(input logic [COUNT_W-1:0] c);
    logic [15:0] hb;
    logic [4:0]  lo;
    logic [3:0]  lo_tens;
    logic [3:0]  lo_ones;
    logic [4:0]  s0;
    logic [4:0]  s1;
    logic [4:0]  s2;
    logic [4:0]  s3;
    bcd4_t       d;
    hb = hi_bcd(c[9:5]);
    lo = c[4:0];
    if (lo >= 5'd30) lo_tens = 4'd3;
    else if (lo >= 5'd20) lo_tens = 4'd2;
    else if (lo >= 5'd10) lo_tens = 4'd1;
    else lo_tens = 4'd0;
    lo_ones = 4'(lo - 5'(lo_tens) * 5'd10);
    // Ones digit.
    s0 = {1'b0, hb[3:0]} + {1'b0, lo_ones};
    if (s0 > 5'd9) begin
      d[0] = 4'(s0 - 5'd10);
      s1 = {1'b0, hb[7:4]} + {1'b0, lo_tens} + 5'd1;
    end else begin
      d[0] = s0[3:0];
      s1 = {1'b0, hb[7:4]} + {1'b0, lo_tens};
    end
    // Tens digit.
    if (s1 > 5'd9) begin
      d[1] = 4'(s1 - 5'd10);
      s2 = {1'b0, hb[11:8]} + 5'd1;
    end else begin
      d[1] = s1[3:0];
      s2 = {1'b0, hb[11:8]};
    end
    // Hundreds and thousands digits.
    if (s2 > 5'd9) begin
      d[2] = 4'(s2 - 5'd10);
      s3 = {1'b0, hb[15:12]} + 5'd1;
    end else begin
      d[2] = s2[3:0];
      s3 = {1'b0, hb[15:12]};
    end
    d[3] = s3[3:0];
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/button_counter_seven_segment_display_core.sv
// Top level of the button press counter with a four-digit display scan.
//
// One beat enters per clock unless m_axis_tready stalls the output, and one
// result beat leaves for each input beat, via input then result register.
// Without stalls, throughput is one beat per cycle, set by the single pass
// of press logic and digit lookup between the counter and result registers;
// a display beat right after a poll beat already sees the new count.
// s_axis_tdata holds buttons [7:0] and digit [10:8]; s_axis_tuser is func
// (0 poll, 1 display). m_axis_tdata holds segments [7:0], digit_code [10:8]
// and count [20:11]; m_axis_tuser is press_taken. cfg_we writes the
// leading zero blanking enable, which resets to 1; write it only while idle.
`default_nettype none
`include "button_counter_seven_segment_display_core_defines.svh"

module button_counter_seven_segment_display_core
  import bcssd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // buttons [7:0], digit [10:8], zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func [0]
  input  wire logic [0:0]             s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // segments [7:0], digit_code [10:8], count [20:11], zero fill
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // press_taken [0]
  output logic [0:0]                  m_axis_tuser,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_wdata
);

  in_item_t           in_item;
  in_item_t           item;
  logic               item_valid;
  logic               advance;
  logic               poll_fire;
  logic [COUNT_W-1:0] press_count;
  poll_res_t          poll_res;
  logic [7:0]         disp_segments;
  logic [2:0]         disp_code;
  logic               blank_en;
  logic               out_valid;
  logic               out_valid_next;
  out_item_t          out_q;
  out_item_t          out_next;

  assign in_item.func = s_axis_tuser[0];
  assign in_item.buttons = s_axis_tdata[7:0];
  assign in_item.digit = s_axis_tdata[10:8];

  // Blanking enable register.
  always_ff @(posedge clk) begin
    if (rst) begin
      blank_en <= 1'b1;
    end else if (cfg_we) begin
      blank_en <= cfg_wdata;
    end
  end

  bcssd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // The held beat moves on when the result register is free or draining.
  assign advance = item_valid && (!out_valid || m_axis_tready);
  assign poll_fire = advance && (item.func == FUNC_POLL);

  bcssd_poll u_poll (
    .clk         (clk),
    .rst         (rst),
    .fire        (poll_fire),
    .buttons     (item.buttons),
    .press_count (press_count),
    .res         (poll_res)
  );

  bcssd_disp u_disp (
    .digit       (item.digit),
    .press_count (press_count),
    .blank_en    (blank_en),
    .segments    (disp_segments),
    .digit_code  (disp_code)
  );

  // Assemble the result beat.
  always_comb begin
    if (item.func == FUNC_POLL) begin
      out_next.segments = SEG_BLANK;
      out_next.digit_code = CODE_BUTTONS;
      out_next.count = poll_res.count;
      out_next.press_taken = poll_res.taken;
    end else begin
      out_next.segments = disp_segments;
      out_next.digit_code = disp_code;
      out_next.count = press_count;
      out_next.press_taken = 1'b0;
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_next = out_valid;
    if (advance) begin
      out_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= out_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {3'b000, out_q.count, out_q.digit_code, out_q.segments};
  assign m_axis_tuser[0] = out_q.press_taken;

  // A poll beat always reports a blank display and the button select.
  `BCSSD_ASSERT_NEXT(a_poll_result, clk, rst, poll_fire, out_q.segments == SEG_BLANK && out_q.digit_code == CODE_BUTTONS)
  // A taken press always moves the counter.
  `BCSSD_ASSERT_NEXT(a_press_moves, clk, rst, poll_fire && poll_res.taken, press_count != $past(press_count) && out_q.count == press_count)
  // A display beat leaves the counter alone and reports no press.
  `BCSSD_ASSERT_NEXT(a_show_keeps, clk, rst, advance && item.func == FUNC_SHOW, $stable(press_count) && !out_q.press_taken)
  // A held beat that cannot move stays in place.
  `BCSSD_ASSERT_NEXT(a_hold_item, clk, rst, item_valid && !advance, item_valid && $stable(item))

endmodule

`default_nettype wire

// File: rtl/bcssd_in_stage.sv
// Input register that holds one accepted beat until the core consumes it.
`default_nettype none

module bcssd_in_stage
  import bcssd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     advance,
  output logic          item_valid,
  output in_item_t      item
);

  logic     hold_valid;
  logic     hold_valid_next;
  in_item_t hold;

  // Room exists when empty or when the held beat leaves this cycle.
  assign in_ready = !hold_valid || advance;

  always_comb begin
    hold_valid_next = hold_valid;
    if (in_valid && in_ready) begin
      hold_valid_next = 1'b1;
    end else if (advance) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= in_item;
    end
  end

  assign item_valid = hold_valid;
  assign item = hold;

endmodule

`default_nettype wire

// File: rtl/bcssd_poll.sv
// Press detection and counter state for button poll items.
`default_nettype none

module bcssd_poll
  import bcssd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic [7:0]         buttons,
  output logic [COUNT_W-1:0]      press_count,
  output poll_res_t               res
);

  logic               released;
  logic               released_next;
  logic [7:0]         last_sample;
  logic [7:0]         last_sample_next;
  logic [COUNT_W-1:0] press_count_next;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W:0]   sum_adj;
  logic               taken;

  // Add 255 minus the sample, then fold a count of 1024 or more back down.
  always_comb begin
    sum = {1'b0, press_count} + {3'b000, ~buttons};
    if (sum >= COUNT_WRAP_AT) begin
      sum_adj = sum - COUNT_DROP;
    end else begin
      sum_adj = sum;
    end
  end

  // A press is taken on the first non-idle sample after release, or on a change.
  always_comb begin
    taken = 1'b0;
    released_next = released;
    last_sample_next = last_sample;
    if (fire) begin
      if (buttons != BUTTONS_IDLE) begin
        if (released) begin
          taken = 1'b1;
          released_next = 1'b0;
        end else if (buttons != last_sample) begin
          taken = 1'b1;
        end
        last_sample_next = buttons;
      end else begin
        released_next = 1'b1;
      end
    end
    press_count_next = taken ? sum_adj[COUNT_W-1:0] : press_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_count <= '0;
      released <= 1'b1;
      last_sample <= '0;
    end else begin
      press_count <= press_count_next;
      released <= released_next;
      last_sample <= last_sample_next;
    end
  end

  assign res.count = press_count_next;
  assign res.taken = taken;

endmodule

`default_nettype wire

// File: rtl/bcssd_disp.sv
// Segment and decoder select lookup for one display digit.
`default_nettype none

module bcssd_disp
  import bcssd_pkg::*;
(
  input  wire logic [2:0]         digit,
  input  wire logic [COUNT_W-1:0] press_count,
  input  wire logic               blank_en,
  output logic [7:0]              segments,
  output logic [2:0]              digit_code
);

  bcd4_t      dec;
  logic [3:0] dsel;
  logic       blank;

  assign dec = count_to_bcd(press_count);

  // Pick the digit, its select code and whether it is a leading zero.
  always_comb begin
    dsel = dec[0];
    blank = 1'b1;
    digit_code = CODE_IDLE;
    case (digit)
      DIGIT_THOU: begin
        dsel = dec[3];
        digit_code = CODE_DIG1;
        blank = blank_en && (press_count < LZ_THOU);
      end
      DIGIT_HUND: begin
        dsel = dec[2];
        digit_code = CODE_DIG2;
        blank = blank_en && (press_count < LZ_HUND);
      end
      DIGIT_TENS: begin
        dsel = dec[1];
        digit_code = CODE_DIG3;
        blank = blank_en && (press_count < LZ_TENS);
      end
      DIGIT_ONES: begin
        dsel = dec[0];
        digit_code = CODE_DIG4;
        blank = 1'b0;
      end
      default: begin
        dsel = dec[0];
        digit_code = CODE_IDLE;
        blank = 1'b1;
      end
    endcase
    segments = blank ? SEG_BLANK : seg_of_digit(dsel);
  end

endmodule

`default_nettype wire
